FILE: hdl/smie_pkg.sv
// ----------------------------------------------------------------------------
// smie_pkg: shared types and constants for the stack machine executor
// Opcodes, error codes, register addresses and the front-to-back queue entry.
// ----------------------------------------------------------------------------
`default_nettype none
package smie_pkg;

  localparam logic [5:0] OP_BEGIN = 6'd10;
  localparam logic [5:0] OP_POP   = 6'd11;
  localparam logic [5:0] OP_ADD   = 6'd12;
  localparam logic [5:0] OP_SUB   = 6'd13;
  localparam logic [5:0] OP_MUL   = 6'd14;
  localparam logic [5:0] OP_DIV   = 6'd15;
  localparam logic [5:0] OP_OUT   = 6'd16;
  localparam logic [5:0] OP_IN    = 6'd17;
  localparam logic [5:0] OP_RET   = 6'd18;
  localparam logic [5:0] OP_END   = 6'd19;
  localparam logic [5:0] OP_CALL  = 6'd20;
  localparam logic [5:0] OP_JMP   = 6'd21;
  localparam logic [5:0] OP_JEQ   = 6'd22;
  localparam logic [5:0] OP_JNE   = 6'd23;
  localparam logic [5:0] OP_JA    = 6'd24;
  localparam logic [5:0] OP_JAE   = 6'd25;
  localparam logic [5:0] OP_JB    = 6'd26;
  localparam logic [5:0] OP_JBE   = 6'd27;
  localparam logic [5:0] OP_PUSH  = 6'd30;
  localparam logic [5:0] OP_POPR  = 6'd40;
  localparam logic [5:0] OP_PUSHR = 6'd41;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_UNDER = 3'd1;
  localparam logic [2:0] ERR_OVER  = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_REG   = 3'd4;
  localparam logic [2:0] ERR_LABEL = 3'd5;
  localparam logic [2:0] ERR_OPC   = 3'd6;

  localparam logic [0:0] REG_PROGRAM_LENGTH = 1'b0;

  // classified word handed from front to back
  typedef struct packed {
    logic [5:0]  mode;
    logic [31:0] argument;
    logic [31:0] in_value;
    logic [2:0]  pre_err;  // opcode, label or register error found up front
  } smie_item_t;

endpackage
`default_nettype wire

FILE: hdl/smie_front.sv
// ----------------------------------------------------------------------------
// smie_front: instruction intake and classification
// Accepts a word, checks opcode, label and register index, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none
module smie_front
  import smie_pkg::*;
#(
  parameter int NUM_REGS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  mode,
  input  wire logic [31:0] argument,
  input  wire logic [31:0] in_value,
  input  wire logic [15:0] program_length,
  output logic             q_valid,
  output smie_item_t       q_item,
  input  wire logic        q_pop
);

  localparam int QD = 2;

  smie_item_t  entries [QD];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        known, noarg, is_jump, is_reg;
  logic [2:0]  err;

  always_comb begin
    known   = (mode >= OP_BEGIN && mode <= OP_JBE) || mode == OP_PUSH ||
              mode == OP_POPR || mode == OP_PUSHR;
    noarg   = mode >= OP_BEGIN && mode <= OP_END;
    is_jump = mode >= OP_CALL && mode <= OP_JBE;
    is_reg  = mode == OP_POPR || mode == OP_PUSHR;
    if (!known || (noarg && argument != 32'd0)) begin
      err = ERR_OPC;
    end else if (is_jump && (argument[31] || argument[30:16] != 15'd0 ||
                             argument[15:0] >= program_length)) begin
      err = ERR_LABEL;
    end else if (is_reg && (argument[31] || {1'b0, argument} >= 33'(NUM_REGS))) begin
      err = ERR_REG;
    end else begin
      err = ERR_NONE;
    end
  end

  assign in_stall = count == 2'(QD);
  assign push     = in_valid && !in_stall;
  assign q_valid  = count != 2'd0;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{mode: mode, argument: argument, in_value: in_value,
                           pre_err: err};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/smie_div.sv
// ----------------------------------------------------------------------------
// smie_div: iterative signed divider
// Truncating 32-bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module smie_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy;
  logic [5:0]  step;
  logic [31:0] rem, quo, dvs;
  logic        neg;
  logic [32:0] trial;

  assign trial    = {rem[31:0], quo[31]} - {1'b0, dvs};
  assign quotient = neg ? 32'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 6'd0;
        rem  <= 32'd0;
        quo  <= dividend[31] ? 32'(-dividend) : dividend;
        dvs  <= divisor[31] ? 32'(-divisor) : divisor;
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        // restoring step on the magnitudes
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        step <= step + 6'd1;
        if (step == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/smie_back.sv
// ----------------------------------------------------------------------------
// smie_back: instruction execution
// Holds pc, stacks and registers, runs one queued word and emits its result.
// ----------------------------------------------------------------------------
`default_nettype none
module smie_back
  import smie_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int CALL_DEPTH  = 64,
  parameter int NUM_REGS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  smie_item_t       q_item,
  output logic             q_pop,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [15:0]      next_pc,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             ended,
  output logic [2:0]       error_code
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int DA = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(CALL_DEPTH + 1);
  localparam int CA = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int RA = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t      state;
  smie_item_t  cur;
  logic [15:0] pc;
  logic [DW-1:0] depth;
  logic [CW-1:0] rdepth;
  logic [31:0] dstack [STACK_DEPTH];
  logic [15:0] rstack [CALL_DEPTH];
  logic [31:0] regs [NUM_REGS];
  logic [31:0] a, b;
  logic [15:0] ret_addr;
  logic [RA-1:0] ridx;
  logic [DA-1:0] top_addr, sec_addr, push_addr;
  logic        div_start, div_done;
  logic [31:0] div_q;
  logic [31:0] prod;

  // execute-cycle decode
  logic [2:0]  err;
  logic        bin_op, jcc;
  logic        take;
  logic [15:0] npc;

  assign ridx      = RA'(cur.argument);
  assign top_addr  = DA'(depth - DW'(1));
  assign sec_addr  = DA'(depth - DW'(2));
  assign push_addr = DA'(depth);
  assign prod      = a * b;

  smie_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (a),
    .divisor  (b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    bin_op = cur.mode >= OP_ADD && cur.mode <= OP_DIV;
    jcc    = cur.mode >= OP_JEQ && cur.mode <= OP_JBE;
    err    = cur.pre_err;
    if (err == ERR_NONE) begin
      if (bin_op || jcc) begin
        if (depth < DW'(2)) err = ERR_UNDER;
        else if (cur.mode == OP_DIV && b == 32'd0) err = ERR_DIV0;
      end else if (cur.mode == OP_POP || cur.mode == OP_OUT || cur.mode == OP_POPR) begin
        if (depth == DW'(0)) err = ERR_UNDER;
      end else if (cur.mode == OP_IN || cur.mode == OP_PUSH || cur.mode == OP_PUSHR) begin
        if (depth >= DW'(STACK_DEPTH)) err = ERR_OVER;
      end else if (cur.mode == OP_RET) begin
        if (rdepth == CW'(0)) err = ERR_UNDER;
      end else if (cur.mode == OP_CALL) begin
        if (rdepth >= CW'(CALL_DEPTH)) err = ERR_OVER;
      end
    end
    case (cur.mode)
      OP_JEQ:  take = a == b;
      OP_JNE:  take = a != b;
      OP_JA:   take = $signed(a) > $signed(b);
      OP_JAE:  take = $signed(a) >= $signed(b);
      OP_JB:   take = $signed(a) < $signed(b);
      default: take = $signed(a) <= $signed(b);
    endcase
    npc = pc + 16'd1;
    if (err != ERR_NONE) npc = pc;
    else if (cur.mode == OP_RET) npc = ret_addr + 16'd1;
    else if (cur.mode == OP_END) npc = 16'd0;
    else if (cur.mode == OP_CALL || cur.mode == OP_JMP) npc = cur.argument[15:0];
    else if (jcc && take) npc = cur.argument[15:0];
  end

  assign q_pop     = state == S_IDLE && q_valid && !(res_valid && res_stall);
  assign div_start = state == S_EXEC && err == ERR_NONE && cur.mode == OP_DIV;

  always_ff @(posedge clk) begin
    // data and return stack reads, registered
    a        <= dstack[top_addr];
    b        <= dstack[sec_addr];
    ret_addr <= rstack[CA'(rdepth - CW'(1))];
    if (state == S_IDLE && q_pop) cur <= q_item;

    if (!rst && state == S_EXEC && err == ERR_NONE) begin
      case (cur.mode)
        OP_ADD:  dstack[sec_addr] <= a + b;
        OP_SUB:  dstack[sec_addr] <= a - b;
        OP_MUL:  dstack[sec_addr] <= prod;
        OP_IN:   dstack[push_addr] <= cur.in_value;
        OP_PUSH: dstack[push_addr] <= cur.argument;
        OP_PUSHR: dstack[push_addr] <= regs[ridx];
        default: ;
      endcase
      if (cur.mode == OP_CALL) rstack[CA'(rdepth)] <= pc;
    end
    if (!rst && state == S_DIV && div_done) dstack[sec_addr] <= div_q;

    if (rst) begin
      state     <= S_IDLE;
      pc        <= 16'd0;
      depth     <= '0;
      rdepth    <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= 32'd0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_pop) state <= S_READ;
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (div_start) begin
            state <= S_DIV;
          end else begin
            state      <= S_IDLE;
            res_valid  <= 1'b1;
            next_pc    <= npc;
            error_code <= err;
            out_valid  <= err == ERR_NONE && cur.mode == OP_OUT;
            out_value  <= (err == ERR_NONE && cur.mode == OP_OUT) ? a : 32'd0;
            ended      <= err == ERR_NONE && cur.mode == OP_END;
            if (err == ERR_NONE) begin
              pc <= npc;
              if (bin_op || cur.mode == OP_POP || cur.mode == OP_OUT ||
                  cur.mode == OP_POPR) depth <= depth - DW'(1);
              if (jcc) depth <= depth - DW'(2);
              if (cur.mode == OP_IN || cur.mode == OP_PUSH || cur.mode == OP_PUSHR)
                depth <= depth + DW'(1);
              if (cur.mode == OP_RET) rdepth <= rdepth - CW'(1);
              if (cur.mode == OP_CALL) rdepth <= rdepth + CW'(1);
              if (cur.mode == OP_POPR) regs[ridx] <= a;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state      <= S_IDLE;
            res_valid  <= 1'b1;
            next_pc    <= pc + 16'd1;
            error_code <= ERR_NONE;
            out_valid  <= 1'b0;
            out_value  <= 32'd0;
            ended      <= 1'b0;
            pc         <= pc + 16'd1;
            depth      <= depth - DW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH)) else $error("data depth out of range");
  a_rdepth_range: assert property (@(posedge clk) disable iff (rst)
    rdepth <= CW'(CALL_DEPTH)) else $error("call depth out of range");
  a_err_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && err != ERR_NONE) |=> $stable(pc))
    else $error("pc moved on error");
  a_out_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_valid |-> error_code == ERR_NONE)
    else $error("output on error");

endmodule
`default_nettype wire

FILE: hdl/stack_machine_instruction_execute.sv
// the executor takes one word at a time: S_IDLE pops it from the queue,
// S_READ reads the stacks, S_EXEC executes it, and a divide waits in S_DIV
// for the iterative divider; the result is registered on the result port
// a two-entry queue lets intake continue while the executor is busy
// reset: synchronous; pc, stack depths and registers clear, program_length
// returns to 65535; stack contents stay undefined
// ----------------------------------------------------------------------------
// stack_machine_instruction_execute: stack machine executor top level
// Config port, intake/classify front and executing back joined by a queue.
// ----------------------------------------------------------------------------
`default_nettype none
module stack_machine_instruction_execute
  import smie_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  parameter int CALL_DEPTH  = 64,
  parameter int NUM_REGS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [5:0]  mode,
  input  wire logic [31:0] argument,
  input  wire logic [31:0] in_value,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [15:0]      next_pc,
  output logic             out_valid,
  output logic [31:0]      out_value,
  output logic             ended,
  output logic [2:0]       error_code
);

  logic [15:0] program_length;
  logic        q_valid, q_pop;
  smie_item_t  q_item;
  logic        sel_plen;

  assign pready   = 1'b1;
  assign sel_plen = paddr == {REG_PROGRAM_LENGTH, 1'b0};
  assign prdata   = sel_plen ? {16'd0, program_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= 16'hFFFF;
    end else if (psel && penable && pwrite && sel_plen) begin
      program_length <= pwdata[15:0];
    end
  end

  smie_front #(.NUM_REGS(NUM_REGS)) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .argument       (argument),
    .in_value       (in_value),
    .program_length (program_length),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  smie_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .CALL_DEPTH  (CALL_DEPTH),
    .NUM_REGS    (NUM_REGS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .next_pc    (next_pc),
    .out_valid  (out_valid),
    .out_value  (out_value),
    .ended      (ended),
    .error_code (error_code)
  );

endmodule
`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the stack machine instruction executor
// Drives instruction words with bursty valid, stalls results on a pattern,
// predicts each result with a local copy of pc, stacks and registers, and
// compares field by field. program_length is rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
  import smie_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SDEPTH = 256;
  localparam int CDEPTH = 64;
  localparam int NREGS  = 8;

  typedef struct packed {
    logic [5:0]  mode;
    logic [31:0] argument;
    logic [31:0] in_value;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        out_valid;
    logic [31:0] out_value;
    logic        ended;
    logic [2:0]  error_code;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] mode = '0;
  logic [31:0] argument = '0, in_value = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [15:0] next_pc;
  logic out_valid, ended;
  logic [31:0] out_value;
  logic [2:0] error_code;
  logic in_taken = 1'b0;

  stack_machine_instruction_execute dut (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [15:0] m_pc, m_plen;
  logic [31:0] m_data [SDEPTH];
  int          m_ddepth;
  logic [15:0] m_ret [CDEPTH];
  int          m_rdepth;
  logic [31:0] m_regs [NREGS];

  instr_t   pending_words[$];
  outcome_t expected_outcomes[$];
  int errors = 0;
  int gap_left = 0, burst_left = 0;
  int stall_phase = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("tb: mismatch %s got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic outcome_t execute_instr(input instr_t w);
    outcome_t r;
    logic [31:0] a, b, q;
    logic signed [31:0] sa, sb, sarg;
    logic [2:0] err;
    logic [15:0] npc;
    logic take;
    a = '0; b = '0; take = 1'b0;
    sarg = w.argument;
    npc = m_pc + 16'd1;
    err = ERR_NONE;
    r = '0;
    if (!((w.mode >= OP_BEGIN && w.mode <= OP_JBE) || w.mode == OP_PUSH ||
          w.mode == OP_POPR || w.mode == OP_PUSHR) ||
        (w.mode >= OP_BEGIN && w.mode <= OP_END && w.argument != 0))
      err = ERR_OPC;
    else if (w.mode >= OP_CALL && w.mode <= OP_JBE &&
             (sarg < 0 || sarg >= $signed({16'd0, m_plen})))
      err = ERR_LABEL;
    else if ((w.mode == OP_POPR || w.mode == OP_PUSHR) && (sarg < 0 || sarg >= NREGS))
      err = ERR_REG;
    else if ((w.mode >= OP_ADD && w.mode <= OP_DIV) || (w.mode >= OP_JEQ && w.mode <= OP_JBE)) begin
      if (m_ddepth < 2) err = ERR_UNDER;
      else begin
        a = m_data[m_ddepth-1];
        b = m_data[m_ddepth-2];
        if (w.mode == OP_DIV && b == 0) err = ERR_DIV0;
      end
    end else if (w.mode == OP_POP || w.mode == OP_OUT || w.mode == OP_POPR) begin
      if (m_ddepth < 1) err = ERR_UNDER;
    end else if (w.mode == OP_IN || w.mode == OP_PUSH || w.mode == OP_PUSHR) begin
      if (m_ddepth >= SDEPTH) err = ERR_OVER;
    end else if (w.mode == OP_RET) begin
      if (m_rdepth < 1) err = ERR_UNDER;
    end else if (w.mode == OP_CALL) begin
      if (m_rdepth >= CDEPTH) err = ERR_OVER;
    end
    if (err != ERR_NONE) npc = m_pc;
    else begin
      sa = a; sb = b;
      case (w.mode)
        OP_POP: m_ddepth--;
        OP_ADD: begin m_ddepth--; m_data[m_ddepth-1] = a + b; end
        OP_SUB: begin m_ddepth--; m_data[m_ddepth-1] = a - b; end
        OP_MUL: begin m_ddepth--; m_data[m_ddepth-1] = a * b; end
        OP_DIV: begin
          // most negative over minus one wraps
          if (a == 32'h8000_0000 && b == 32'hffff_ffff) q = a;
          else q = sa / sb;
          m_ddepth--; m_data[m_ddepth-1] = q;
        end
        OP_OUT: begin
          m_ddepth--; r.out_valid = 1'b1; r.out_value = m_data[m_ddepth];
        end
        OP_IN: begin m_data[m_ddepth] = w.in_value; m_ddepth++; end
        OP_RET: begin m_rdepth--; npc = m_ret[m_rdepth] + 16'd1; end
        OP_END: begin npc = '0; r.ended = 1'b1; end
        OP_CALL: begin m_ret[m_rdepth] = m_pc; m_rdepth++; npc = w.argument[15:0]; end
        OP_JMP: npc = w.argument[15:0];
        OP_PUSH: begin m_data[m_ddepth] = w.argument; m_ddepth++; end
        OP_POPR: begin m_ddepth--; m_regs[w.argument[2:0]] = m_data[m_ddepth]; end
        OP_PUSHR: begin m_data[m_ddepth] = m_regs[w.argument[2:0]]; m_ddepth++; end
        OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE: begin
          m_ddepth -= 2;
          case (w.mode)
            OP_JEQ: take = sa == sb;
            OP_JNE: take = sa != sb;
            OP_JA:  take = sa > sb;
            OP_JAE: take = sa >= sb;
            OP_JB:  take = sa < sb;
            default: take = sa <= sb;
          endcase
          if (take) npc = w.argument[15:0];
        end
        default: ;
      endcase
      m_pc = npc;
    end
    r.next_pc = npc;
    r.error_code = err;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        void'(pending_words.pop_front());
      end
      if (in_valid && !in_taken) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        mode <= pending_words[0].mode;
        argument <= pending_words[0].argument;
        in_value <= pending_words[0].in_value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 1'b0;
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 40) % 3)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(2, 0) == 0);
        default: res_stall <= (stall_phase % 7) < 4;
      endcase
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    outcome_t got, want;
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall)
        expected_outcomes.push_back(execute_instr('{mode, argument, in_value}));
      if (res_valid && !res_stall) begin
        got = '{next_pc, out_valid, out_value, ended, error_code};
        if (expected_outcomes.size() == 0) report("unexpected word", 0, 0);
        else begin
          want = expected_outcomes.pop_front();
          if (got.next_pc !== want.next_pc) report("next_pc", got.next_pc, want.next_pc);
          if (got.out_valid !== want.out_valid) report("out_valid", got.out_valid, want.out_valid);
          if (got.out_value !== want.out_value) report("out_value", got.out_value, want.out_value);
          if (got.ended !== want.ended) report("ended", got.ended, want.ended);
          if (got.error_code !== want.error_code)
            report("error_code", got.error_code, want.error_code);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(5, 0) - 2;
      default: return $urandom();
    endcase
  endfunction

  task automatic add(input logic [5:0] m, input logic [31:0] arg, input logic [31:0] iv);
    pending_words.push_back('{m, arg, iv});
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_outcomes.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_plen(input logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_PROGRAM_LENGTH, 1'b0};
    pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    m_plen = v;
  endtask

  // mostly well-formed code: frequent pushes, mostly in-range labels
  task automatic random_phase(input int n);
    logic [5:0] ops [21];
    logic [5:0] m;
    logic [31:0] arg;
    ops = '{OP_BEGIN, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OUT, OP_IN, OP_RET,
            OP_END, OP_CALL, OP_JMP, OP_JEQ, OP_JNE, OP_JA, OP_JAE, OP_JB, OP_JBE,
            OP_PUSH, OP_POPR, OP_PUSHR};
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9, 0))
        0, 1, 2: m = ($urandom_range(1, 0)) ? OP_PUSH : OP_IN;
        3: m = 6'($urandom_range(63, 0));
        default: m = ops[$urandom_range(20, 0)];
      endcase
      arg = 0;
      if (m >= OP_CALL && m <= OP_JBE)
        arg = ($urandom_range(7, 0) == 0) ? rand_word()
              : $urandom_range(m_plen == 0 ? 0 : m_plen - 1, 0);
      else if (m == OP_POPR || m == OP_PUSHR)
        arg = ($urandom_range(7, 0) == 0) ? rand_word() : $urandom_range(NREGS - 1, 0);
      else if (m == OP_PUSH || $urandom_range(15, 0) == 0) arg = rand_word();
      add(m, arg, rand_word());
    end
  endtask

  initial begin
    m_pc = '0; m_plen = 16'hffff; m_ddepth = 0; m_rdepth = 0;
    for (int i = 0; i < NREGS; i++) m_regs[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: underflows, extremes, division corner cases, registers
    add(OP_POP, 0, 0);
    add(OP_RET, 0, 0);
    add(OP_BEGIN, 1, 0);
    add(6'd63, 0, 0);
    add(OP_POPR, 8, 0);
    add(OP_PUSHR, 32'hffff_ffff, 0);
    add(OP_JMP, 32'h8000_0000, 0);
    add(OP_PUSH, 32'hffff_ffff, 0);
    add(OP_IN, 0, 32'h8000_0000);
    add(OP_DIV, 0, 0);
    add(OP_PUSH, 0, 0);
    add(OP_PUSH, 7, 0);
    add(OP_DIV, 0, 0);
    add(OP_OUT, 0, 0);
    add(OP_PUSH, 32'h7fff_ffff, 0);
    add(OP_POPR, 7, 0);
    add(OP_PUSHR, 7, 0);
    add(OP_PUSHR, 7, 0);
    add(OP_MUL, 0, 0);
    add(OP_CALL, 16'hfffe, 0);
    add(OP_JMP, 16'hffff, 0);
    add(OP_JBE, 3, 0);
    add(OP_RET, 0, 0);
    add(OP_END, 0, 0);
    wait_idle();
    // fill data and call stacks past their limits
    for (int i = 0; i < SDEPTH + 2; i++) add(OP_PUSH, $urandom(), 0);
    for (int i = 0; i < CDEPTH + 2; i++) add(OP_CALL, $urandom_range(500, 0), 0);
    for (int i = 0; i < CDEPTH + 2; i++) add(OP_RET, 0, 0);
    wait_idle();
    write_plen(16'd0);
    random_phase(30);
    wait_idle();
    write_plen(16'd1);
    random_phase(30);
    wait_idle();
    write_plen(16'd40);
    random_phase(130);
    wait_idle();
    write_plen(16'hffff);
    random_phase(50);
    wait_idle();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
